>>> hdl/frpr_pkg.sv
// ----------------------------------------------------------------------------
// frpr_pkg
// shared constants, codes and the crc byte step for the framed packet receiver
// ----------------------------------------------------------------------------
package frpr_pkg;

  // frame store depth, a power of two so that store addresses wrap by truncation
  localparam int BUF_DEPTH = 512;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int PW        = AW + 1;

  localparam int HDR_BYTES     = 8;
  localparam int TRAILER_BYTES = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_MESSAGE  = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  // reflected crc-16 over one byte, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/framed_packet_receiver_crc16.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16
// link byte receiver: magic search, header check and crc-16 over a circular
// frame store
// ----------------------------------------------------------------------------
// usage: raise start with in_cmd (push, read, release) while busy is low; the
// beat is taken at that edge. a read or a push into a store that is not full
// raises busy until the result is shown. every command gives exactly one
// result: out_valid is high for one cycle with the result ports, and the
// receiver cannot hold it off. the error counters on the result ports
// always show the counts after the last command. release, the unused command
// and a push into a full store are answered from idle. a read fetches the
// length word and, for a delivered frame and a valid index, the payload byte.
// a push scans for the magic, checks version and length, feeds header and
// payload to the crc unit and checks the trailer via the single store read port.
// configuration writes on cfg_we take effect at once; write them while idle.
// reset clears all control state and counters; store contents stay undefined
// and are only used after being written. a full store on push clears it.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16
  import frpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_read_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_msg_type,
  output logic [15:0] out_msg_sequence,
  output logic [8:0]  out_body_length,
  output logic [7:0]  out_read_byte,
  output logic [15:0] out_frame_error_count,
  output logic [15:0] out_crc_error_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SCAN_FIRST, S_SCAN, S_VER, S_LEN_LO, S_LEN_HI, S_CRC,
    S_CHK_LO, S_CHK_HI, S_TYPE, S_SEQ_LO, S_SEQ_HI, S_RD_LO, S_RD_HI, S_RD_DATA
  } state_t;

  logic [7:0] mem [BUF_DEPTH];

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] exp_r, exp_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   ff_r, ff_nxt;
  logic [15:0]   cf_r, cf_nxt;
  logic          dlv_r, dlv_nxt;
  logic [15:0]   magic_r;
  logic [7:0]    ver_r;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic [15:0]   plen_r, plen_nxt;
  logic [8:0]    idx_r, idx_nxt;
  logic [7:0]    rdata_r;

  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [7:0]    otype_r, otype_nxt;
  logic [15:0]   oseq_r, oseq_nxt;
  logic [8:0]    olen_r, olen_nxt;
  logic [7:0]    obyte_r, obyte_nxt;

  logic          crc_init, crc_en;
  logic [15:0]   crc_val;

  logic          accept;
  logic [AW-1:0] raddr, waddr;
  logic          wen;
  logic [PW-1:0] off;
  logic [16:0]   total;
  logic [15:0]   word;
  logic [PW-1:0] rel_n;

  frpr_crc u_crc (
    .clk  (clk),
    .init (crc_init),
    .en   (crc_en),
    .data (rdata_r),
    .crc  (crc_val)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign waddr  = head_r + fill_r[AW-1:0];
  // read address follows the next head and position, so data lines up with pos_r
  assign raddr  = head_nxt + pos_nxt[AW-1:0];
  assign off    = pos_r - PW'(1);
  assign total  = {1'b0, plen_nxt} + 17'(HDR_BYTES + TRAILER_BYTES);
  assign word   = {rdata_r, lo_r};
  assign rel_n  = (exp_r > fill_r) ? fill_r : exp_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    exp_nxt   = exp_r;
    pos_nxt   = pos_r;
    ff_nxt    = ff_r;
    cf_nxt    = cf_r;
    dlv_nxt   = dlv_r;
    prev_nxt  = prev_r;
    lo_nxt    = lo_r;
    plen_nxt  = plen_r;
    idx_nxt   = idx_r;
    wen       = 1'b0;
    crc_init  = 1'b0;
    crc_en    = 1'b0;
    ov_nxt    = 1'b0;
    ost_nxt   = ST_NONE;
    otype_nxt = 8'd0;
    oseq_nxt  = 16'd0;
    olen_nxt  = 9'd0;
    obyte_nxt = 8'd0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = in_read_index;
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              if (fill_r == PW'(BUF_DEPTH)) begin
                head_nxt = '0;
                fill_nxt = '0;
                exp_nxt  = '0;
                dlv_nxt  = 1'b0;
                ff_nxt   = ff_r + 16'd1;
                ov_nxt   = 1'b1;
                ost_nxt  = ST_OVERFLOW;
              end else begin
                wen       = 1'b1;
                fill_nxt  = fill_r + PW'(1);
                pos_nxt   = '0;
                state_nxt = S_PREP;
              end
            end
            CMD_READ: begin
              pos_nxt   = PW'(6);
              state_nxt = S_RD_LO;
            end
            CMD_RELEASE: begin
              if (dlv_r) begin
                head_nxt = head_r + rel_n[AW-1:0];
                fill_nxt = fill_r - rel_n;
                exp_nxt  = '0;
                dlv_nxt  = 1'b0;
              end
              ov_nxt = 1'b1;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      // re-issue the read after the write edge
      S_PREP: begin
        pos_nxt   = '0;
        state_nxt = S_SCAN_FIRST;
      end
      S_SCAN_FIRST: begin
        prev_nxt  = rdata_r;
        pos_nxt   = PW'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if ((pos_r >= fill_r) ||
            ((prev_r == magic_r[7:0]) && (rdata_r == magic_r[15:8]))) begin
          head_nxt = head_r + off[AW-1:0];
          fill_nxt = fill_r - off;
          if (fill_nxt < PW'(HDR_BYTES)) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = PW'(2);
            state_nxt = S_VER;
          end
        end else begin
          prev_nxt = rdata_r;
          pos_nxt  = pos_r + PW'(1);
        end
      end
      S_VER: begin
        if (rdata_r != ver_r) begin
          head_nxt  = head_r + AW'(2);
          fill_nxt  = fill_r - PW'(2);
          ff_nxt    = ff_r + 16'd1;
          ov_nxt    = 1'b1;
          ost_nxt   = ST_BAD;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = PW'(6);
          state_nxt = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        lo_nxt    = rdata_r;
        pos_nxt   = PW'(7);
        state_nxt = S_LEN_HI;
      end
      S_LEN_HI: begin
        plen_nxt = word;
        if (total > 17'(BUF_DEPTH)) begin
          head_nxt  = '0;
          fill_nxt  = '0;
          dlv_nxt   = 1'b0;
          ff_nxt    = ff_r + 16'd1;
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OVERFLOW;
          state_nxt = S_IDLE;
        end else begin
          exp_nxt = total[PW-1:0];
          if (fill_r < total[PW-1:0]) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            crc_init  = 1'b1;
            pos_nxt   = '0;
            state_nxt = S_CRC;
          end
        end
      end
      S_CRC: begin
        crc_en  = 1'b1;
        pos_nxt = pos_r + PW'(1);
        if (pos_r == plen_r[PW-1:0] + PW'(HDR_BYTES - 1)) begin
          state_nxt = S_CHK_LO;
        end
      end
      S_CHK_LO: begin
        lo_nxt    = rdata_r;
        pos_nxt   = pos_r + PW'(1);
        state_nxt = S_CHK_HI;
      end
      S_CHK_HI: begin
        if (word != crc_val) begin
          head_nxt  = head_r + AW'(2);
          fill_nxt  = fill_r - PW'(2);
          exp_nxt   = '0;
          cf_nxt    = cf_r + 16'd1;
          ov_nxt    = 1'b1;
          ost_nxt   = ST_BAD;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = PW'(3);
          state_nxt = S_TYPE;
        end
      end
      S_TYPE: begin
        prev_nxt  = rdata_r;
        pos_nxt   = PW'(4);
        state_nxt = S_SEQ_LO;
      end
      S_SEQ_LO: begin
        lo_nxt    = rdata_r;
        pos_nxt   = PW'(5);
        state_nxt = S_SEQ_HI;
      end
      S_SEQ_HI: begin
        dlv_nxt   = 1'b1;
        ov_nxt    = 1'b1;
        ost_nxt   = ST_MESSAGE;
        otype_nxt = prev_r;
        oseq_nxt  = word;
        olen_nxt  = plen_r[8:0];
        state_nxt = S_IDLE;
      end
      S_RD_LO: begin
        lo_nxt    = rdata_r;
        pos_nxt   = PW'(7);
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        if (dlv_r && ({7'd0, idx_r} < word)) begin
          pos_nxt   = PW'(idx_r) + PW'(HDR_BYTES);
          state_nxt = S_RD_DATA;
        end else begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_READ;
          state_nxt = S_IDLE;
        end
      end
      S_RD_DATA: begin
        ov_nxt    = 1'b1;
        ost_nxt   = ST_READ;
        obyte_nxt = rdata_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= in_data_byte;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      exp_r   <= '0;
      ff_r    <= '0;
      cf_r    <= '0;
      dlv_r   <= 1'b0;
      magic_r <= '0;
      ver_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      exp_r   <= exp_nxt;
      ff_r    <= ff_nxt;
      cf_r    <= cf_nxt;
      dlv_r   <= dlv_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_MAGIC) begin
          magic_r <= cfg_data;
        end else begin
          ver_r <= cfg_data[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    prev_r  <= prev_nxt;
    lo_r    <= lo_nxt;
    plen_r  <= plen_nxt;
    idx_r   <= idx_nxt;
    ost_r   <= ost_nxt;
    otype_r <= otype_nxt;
    oseq_r  <= oseq_nxt;
    olen_r  <= olen_nxt;
    obyte_r <= obyte_nxt;
  end

  assign out_valid             = ov_r;
  assign out_status            = ost_r;
  assign out_msg_type          = otype_r;
  assign out_msg_sequence      = oseq_r;
  assign out_body_length       = olen_r;
  assign out_read_byte         = obyte_r;
  assign out_frame_error_count = ff_r;
  assign out_crc_error_count   = cf_r;

endmodule

>>> hdl/frpr_crc.sv
// ----------------------------------------------------------------------------
// frpr_crc
// crc-16 accumulator, one store byte per cycle while en is high
// ----------------------------------------------------------------------------
module frpr_crc
  import frpr_pkg::*;
(
  input  logic        clk,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_r;

  always_ff @(posedge clk) begin
    if (init) begin
      crc_r <= CRC_INIT;
    end else if (en) begin
      crc_r <= crc_byte(crc_r, data);
    end
  end

  assign crc = crc_r;

endmodule

>>> dv/tb_framed_packet_receiver_crc16.sv
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_crc16
// self-checking bench: builds link byte streams of good, corrupted and
// oversized frames around random noise, predicts every result beat and checks
// it field by field under several magic and version settings
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_crc16
  import frpr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  msg_type;
    logic [15:0] msg_sequence;
    logic [8:0]  body_length;
    logic [7:0]  read_byte;
    logic [15:0] frame_errs;
    logic [15:0] crc_errs;
  } rx_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_read_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_msg_type;
  logic [15:0] out_msg_sequence;
  logic [8:0]  out_body_length;
  logic [7:0]  out_read_byte;
  logic [15:0] out_frame_error_count;
  logic [15:0] out_crc_error_count;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  framed_packet_receiver_crc16 uut (.*);

  // predictor state
  logic [7:0]  rx_store [BUF_DEPTH];
  int unsigned rx_head, rx_fill, rx_total;
  logic [15:0] rx_frame_faults, rx_crc_faults, rx_last_seq;
  bit          rx_delivered;
  logic [15:0] cur_magic;
  logic [7:0]  cur_version;

  rx_result_t  pending_results [$];
  int          mismatches;
  int          beats_sent;
  int          cycles;
  bit          quiet_sender;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("framed_packet_receiver_crc16 regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_bytes(input logic [7:0] bytes [$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) begin
      c = c ^ {8'h00, bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] stored(input int unsigned pos);
    return rx_store[(rx_head + pos) % BUF_DEPTH];
  endfunction

  function automatic logic [15:0] stored_word(input int unsigned pos);
    return {stored(pos + 1), stored(pos)};
  endfunction

  function automatic void drop_bytes(input int unsigned n);
    if (n > rx_fill) n = rx_fill;
    rx_head = (rx_head + n) % BUF_DEPTH;
    rx_fill -= n;
  endfunction

  function automatic void push_predict(input logic [7:0] v, inout rx_result_t r);
    int unsigned off, plen;
    logic [7:0]  span [$];
    if (rx_fill >= BUF_DEPTH) begin
      rx_head = 0; rx_fill = 0; rx_total = 0; rx_delivered = 0;
      rx_frame_faults++;
      r.status = ST_OVERFLOW;
      return;
    end
    rx_store[(rx_head + rx_fill) % BUF_DEPTH] = v;
    rx_fill++;
    // slide to the first magic match
    off = 0;
    while (off + 1 < rx_fill) begin
      if (stored(off) == cur_magic[7:0] && stored(off + 1) == cur_magic[15:8]) break;
      off++;
    end
    drop_bytes(off);
    if (rx_fill < 2 || rx_fill < HDR_BYTES) return;
    if (stored(2) != cur_version) begin
      drop_bytes(2);
      rx_frame_faults++;
      r.status = ST_BAD;
      return;
    end
    plen = stored_word(6);
    if (plen + HDR_BYTES + TRAILER_BYTES > BUF_DEPTH) begin
      rx_head = 0; rx_fill = 0; rx_delivered = 0;
      rx_frame_faults++;
      r.status = ST_OVERFLOW;
      return;
    end
    rx_total = plen + HDR_BYTES + TRAILER_BYTES;
    if (rx_fill < rx_total) return;
    for (int unsigned i = 0; i < HDR_BYTES + plen; i++) span.push_back(stored(i));
    if (stored_word(HDR_BYTES + plen) != crc16_bytes(span)) begin
      drop_bytes(2);
      rx_total = 0;
      rx_crc_faults++;
      r.status = ST_BAD;
      return;
    end
    rx_last_seq = stored_word(4);
    rx_delivered = 1;
    r.status = ST_MESSAGE;
    r.msg_type = stored(3);
    r.msg_sequence = rx_last_seq;
    r.body_length = plen[8:0];
  endfunction

  function automatic rx_result_t predict_beat(input cmd_t c, input logic [7:0] d,
                                              input logic [8:0] idx);
    rx_result_t r;
    r = '0;
    case (c)
      CMD_PUSH: push_predict(d, r);
      CMD_READ: begin
        r.status = ST_READ;
        if (rx_delivered && idx < stored_word(6)) r.read_byte = stored(HDR_BYTES + idx);
      end
      CMD_RELEASE: begin
        if (rx_delivered) begin
          drop_bytes(rx_total);
          rx_total = 0;
          rx_delivered = 0;
        end
      end
      default: ;
    endcase
    r.frame_errs = rx_frame_faults;
    r.crc_errs = rx_crc_faults;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    rx_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_msg_type, out_msg_sequence, out_body_length,
              out_read_byte, out_frame_error_count, out_crc_error_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_beat(input cmd_t c, input logic [7:0] d, input logic [8:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_data_byte <= d;
    in_read_index <= idx;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_beat(c, d, idx));
    beats_sent++;
  endtask

  task automatic push_byte(input logic [7:0] d);
    send_beat(CMD_PUSH, d, 9'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 16'($urandom);
    if (idx == CFG_MAGIC) cur_magic = v;
    else cur_version = v[7:0];
  endtask

  // kind: 0 good, 1 bad crc, 2 bad version, 3 oversized length (header only)
  task automatic send_frame(input int kind, input int unsigned plen);
    logic [7:0]  fb [$];
    logic [15:0] crc;
    fb = '{cur_magic[7:0], cur_magic[15:8],
           (kind == 2) ? cur_version ^ (8'd1 << $urandom_range(0, 7)) : cur_version,
           8'($urandom), 8'($urandom), 8'($urandom), plen[7:0], plen[15:8]};
    if (kind != 3) begin
      repeat (plen) fb.push_back(8'($urandom));
      crc = crc16_bytes(fb);
      if (kind == 1) crc ^= 16'd1 << $urandom_range(0, 15);
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
    end
    foreach (fb[i]) push_byte(fb[i]);
  endtask

  task automatic test_idle_commands();
    send_beat(CMD_READ, 8'd0, 9'd0);
    send_beat(CMD_RELEASE, 8'hFF, 9'h1FF);
    send_beat(CMD_NONE, 8'hA5, 9'd501);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_beat(CMD_READ, 8'h00, 9'h1FF);
  endtask

  task automatic test_directed_frames();
    write_reg(CFG_MAGIC, 16'hFFFF);
    write_reg(CFG_VERSION, 16'h00FF);
    send_frame(0, 0);
    send_beat(CMD_READ, 8'd0, 9'd0);
    push_byte(8'h5A);                       // delivered frame is reported again
    send_beat(CMD_RELEASE, 8'd0, 9'd0);
    write_reg(CFG_MAGIC, 16'h0000);
    write_reg(CFG_VERSION, 16'h0000);
    send_frame(0, 3);
    send_beat(CMD_READ, 8'd0, 9'd2);
    send_beat(CMD_READ, 8'd0, 9'd3);
    send_beat(CMD_RELEASE, 8'd0, 9'd0);
    send_frame(1, 2);
    send_frame(2, 1);
    send_frame(3, 503);
    send_frame(3, 16'hFFFF);
  endtask

  task automatic test_full_store();
    write_reg(CFG_MAGIC, 16'hB562);
    write_reg(CFG_VERSION, 16'h0081);
    send_frame(0, BUF_DEPTH - HDR_BYTES - TRAILER_BYTES);
    send_beat(CMD_READ, 8'd0, 9'd501);
    send_beat(CMD_READ, 8'd0, 9'd502);
    push_byte(8'h3C);                       // store is full: overflow
    send_frame(0, 5);
    send_beat(CMD_RELEASE, 8'd0, 9'd0);
  endtask

  task automatic test_random_stream(input int target);
    int kind, r, plen, phase_end;
    phase_end = beats_sent;
    while (beats_sent < target) begin
      if (beats_sent >= phase_end) begin
        r = $urandom_range(0, 2);
        write_reg(CFG_MAGIC, r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom));
        r = $urandom_range(0, 2);
        write_reg(CFG_VERSION, r == 0 ? 16'h0000 : r == 1 ? 16'h00FF
                                                          : 16'($urandom_range(0, 255)));
        quiet_sender = ($urandom_range(0, 3) == 0);
        phase_end = beats_sent + 200;
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      r = $urandom_range(0, 99);
      kind = r < 70 ? 0 : r < 80 ? 1 : r < 88 ? 2 : r < 93 ? 3 : 4;
      r = $urandom_range(0, 99);
      plen = r < 85 ? $urandom_range(0, 16) : r < 99 ? $urandom_range(17, 80)
                                                     : $urandom_range(400, 502);
      if (kind == 3) send_frame(3, $urandom_range(503, 65535));
      else if (kind == 4) repeat ($urandom_range(2, 9)) push_byte(8'($urandom));
      else send_frame(kind, plen);
      repeat ($urandom_range(0, 4))
        send_beat(CMD_READ, 8'($urandom),
                  $urandom_range(0, 3) == 0 ? 9'($urandom_range(0, 501))
                                            : 9'($urandom_range(0, plen + 1)));
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      if ($urandom_range(0, 9) != 0) send_beat(CMD_RELEASE, 8'($urandom), 9'($urandom));
      if ($urandom_range(0, 14) == 0) send_beat(CMD_NONE, 8'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_NONE;
    in_data_byte = '0;
    in_read_index = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAGIC;
    cfg_data = '0;
    beats_sent = 0;
    quiet_sender = 0;
    rx_head = 0; rx_fill = 0; rx_total = 0;
    rx_frame_faults = 0; rx_crc_faults = 0; rx_last_seq = 0;
    rx_delivered = 0;
    cur_magic = '0;
    cur_version = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_directed_frames();
    test_full_store();
    test_random_stream(1300);

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("framed_packet_receiver_crc16 regression: pass");
    end else begin
      $display("framed_packet_receiver_crc16 regression: fail");
    end
    $finish;
  end

endmodule

>>> framed_packet_receiver_crc16.f
hdl/frpr_pkg.sv
hdl/frpr_crc.sv
hdl/framed_packet_receiver_crc16.sv
dv/tb_framed_packet_receiver_crc16.sv
